### rtl/core/gcq_pkg.sv
// ----------------------------------------------------------------------------
// gcq_pkg
// Shared constants, register indexes and the proximity fraction function of
// the grid clearance cost query block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcq_pkg;

  localparam int CELL_W     = 6;
  localparam int COST_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIM_W      = 7;
  localparam int WEIGHT_W   = 8;
  localparam int FRAC_W     = 17;

  localparam int MAX_WIDTH_DEF   = 64;
  localparam int MAX_HEIGHT_DEF  = 64;
  localparam int SOFT_RADIUS_DEF = 10;
  localparam int HARD_RADIUS_DEF = 3;

  localparam logic [DIM_W-1:0]    MAP_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0]    MAP_HEIGHT_RST = 7'd64;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = 8'd30;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_WEIGHT = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // round(65536 * (1 - sqrt(d2) / s)) by exact integer search
  function automatic logic [FRAC_W-1:0] prox_fraction(input int unsigned d2,
                                                       input int unsigned s);
    longint unsigned lhs;
    longint unsigned q;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    lhs = longint'(d2) << 34;
    lo  = 0;
    hi  = 65536;
    for (int i = 0; i < 18; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        q   = (longint'(131073) - 2 * longint'(mid)) * longint'(s);
        if (lhs <= q * q) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return FRAC_W'(lo);
  endfunction

endpackage

`default_nettype wire

### rtl/core/gcq_if.sv
// ----------------------------------------------------------------------------
// gcq_in_if / gcq_out_if
// Valid/ready channels carrying the input items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcq_in_if import gcq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic              occupied;

  modport source (output valid, kind, cell_x, cell_y, occupied, input ready);
  modport sink   (input valid, kind, cell_x, cell_y, occupied, output ready);
endinterface

interface gcq_out_if import gcq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost_q8;
  logic              blocked;
  logic              clear;

  modport source (output valid, cost_q8, blocked, clear, input ready);
  modport sink   (input valid, cost_q8, blocked, clear, output ready);
endinterface

`default_nettype wire

### rtl/core/grid_clearance_cost_query.sv
// ----------------------------------------------------------------------------
// grid_clearance_cost_query
// Occupancy grid with on-demand clearance cost queries over a square window.
//
//   channel   dir   contents                               handshake
//   cfg       in    cfg_index, cfg_data                    cfg_we, no wait
//   in_ch     in    kind, cell_x, cell_y, occupied         valid/ready
//   out_ch    out   cost_q8, blocked, clear                valid/ready
//
// A write goes through accept, row read and row write back.
// A query in the map steps through 2*R+1 rows, R = max(SOFT_RADIUS, HARD_RADIUS):
// one row word read per cycle through the single memory read port, then
// table lookup and one multiply. Outside the map: no scan.
// Reset clears the valid flags, one per row, all together; no clearing pass.
// A finished result waits in the output register; the next transaction is
// taken meanwhile and only the result load stalls on out_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_clearance_cost_query import gcq_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int SOFT_RADIUS = SOFT_RADIUS_DEF,
  parameter int HARD_RADIUS = HARD_RADIUS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  gcq_in_if.sink                     in_ch,
  gcq_out_if.source                  out_ch
);

  localparam int R    = (SOFT_RADIUS > HARD_RADIUS) ? SOFT_RADIUS : HARD_RADIUS;
  localparam int AW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(2 * R + 1);
  localparam int KW   = $clog2(R + 1);
  localparam int D2W  = $clog2(2 * SOFT_RADIUS * SOFT_RADIUS + 1);
  localparam int TW   = $clog2(SOFT_RADIUS * SOFT_RADIUS + 1);
  localparam int HSQ  = HARD_RADIUS * HARD_RADIUS;
  localparam int SSQ  = SOFT_RADIUS * SOFT_RADIUS;
  localparam int NWIN = 2 * R + 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WREAD  = 8'b0000_0010,
    S_WMOD   = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DRAIN  = 8'b0001_0000,
    S_LOOKUP = 8'b0010_0000,
    S_MULT   = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [DIM_W-1:0]    map_width;
  logic [DIM_W-1:0]    map_height;
  logic [WEIGHT_W-1:0] penalty_weight;
  logic [DIM_W-1:0]    w_eff;
  logic [DIM_W-1:0]    h_eff;

  logic [CELL_W-1:0] qx;
  logic [CELL_W-1:0] qy;
  logic              qocc;

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [MAX_WIDTH-1:0] rd_data;
  logic                 rd_vld;
  logic [MAX_WIDTH-1:0] row;
  logic [MAX_WIDTH-1:0] new_row;

  logic [RW-1:0]    r;
  logic [RW-1:0]    r_dist;
  logic signed [8:0] ny;
  logic             row_ok;
  logic             p_en;
  logic [KW-1:0]    p_ady;

  logic [NWIN-1:0]  win;
  logic [R:0]       hit;
  logic [KW-1:0]    adx;
  logic             sfound;
  logic             hard_any;
  logic             soft_row;
  logic             hard_row;
  logic [D2W-1:0]   d2;

  logic             found;
  logic [D2W-1:0]   best;
  logic             clr;
  logic             best_hard;
  logic             best_soft;

  logic [FRAC_W-1:0] frac_tab [2**TW];
  logic [FRAC_W-1:0] n_q;
  logic [24:0]       prod;

  logic [COST_W-1:0] res_cost;
  logic              res_blk;
  logic              res_clr;
  logic              out_vld;
  logic [COST_W-1:0] out_cost;
  logic              out_blk;
  logic              out_clr;
  logic              out_load;

  logic in_acc;
  logic wr_ok;
  logic outside;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width      <= MAP_WIDTH_RST;
      map_height     <= MAP_HEIGHT_RST;
      penalty_weight <= WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:      map_width      <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT:     map_height     <= cfg_data[DIM_W-1:0];
        REG_PENALTY_WEIGHT: penalty_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (map_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : map_width;
  assign h_eff = (map_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : map_height;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_ok       = ({1'b0, in_ch.cell_x} < DIM_W'(MAX_WIDTH)) &&
                       ({1'b0, in_ch.cell_y} < DIM_W'(MAX_HEIGHT));
  assign outside     = ({1'b0, in_ch.cell_x} >= w_eff) ||
                       ({1'b0, in_ch.cell_y} >= h_eff);

  // row scan addressing
  assign ny     = $signed({3'b000, qy} + 9'(r) - 9'(R));
  assign row_ok = !ny[8] && (ny[7:0] < {1'b0, h_eff});
  assign r_dist = (r >= RW'(R)) ? (r - RW'(R)) : (RW'(R) - r);

  assign rd_en   = (state == S_WREAD) || ((state == S_SCAN) && row_ok);
  assign rd_addr = (state == S_WREAD) ? qy[AW-1:0] : ny[AW-1:0];

  // occupancy memory, one valid flag per row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= row_vld[rd_addr];
    end
    if (state == S_WMOD) begin
      mem[qy[AW-1:0]] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (state == S_WMOD) begin
      row_vld[qy[AW-1:0]] <= 1'b1;
    end
  end

  assign row = rd_vld ? rd_data : '0;

  always_comb begin
    new_row = row;
    new_row[qx[XW-1:0]] = qocc;
  end

  // nearest obstacle within one row word
  always_comb begin
    logic signed [8:0] nx;
    win = '0;
    for (int j = 0; j < NWIN; j++) begin
      nx = $signed({3'b000, qx} + 9'(j) - 9'(R));
      win[j] = !nx[8] && (nx[7:0] < {1'b0, w_eff}) && row[nx[XW-1:0]];
    end
  end

  always_comb begin
    hit = '0;
    for (int k = 0; k <= R; k++) begin
      hit[k] = win[R + k] | win[R - k];
    end
  end

  always_comb begin
    adx      = '0;
    sfound   = 1'b0;
    hard_any = 1'b0;
    for (int k = SOFT_RADIUS; k >= 0; k--) begin
      if (hit[k]) begin
        adx    = KW'(k);
        sfound = 1'b1;
      end
    end
    for (int k = 0; k <= HARD_RADIUS; k++) begin
      hard_any = hard_any | hit[k];
    end
  end

  assign soft_row = (p_ady <= KW'(SOFT_RADIUS));
  assign hard_row = (p_ady <= KW'(HARD_RADIUS));
  assign d2       = D2W'(adx) * D2W'(adx) + D2W'(p_ady) * D2W'(p_ady);

  assign best_hard = found && ({{(32 - D2W){1'b0}}, best} <= 32'(HSQ));
  assign best_soft = found && ({{(32 - D2W){1'b0}}, best} <= 32'(SSQ));

  // proximity fraction table
  for (genvar i = 0; i < 2**TW; i++) begin : g_frac
    assign frac_tab[i] = prox_fraction(i, SOFT_RADIUS);
  end

  assign prod = 25'(penalty_weight) * 25'(n_q) + 25'd128;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p_en  <= 1'b0;
    end else begin
      p_en <= (state == S_SCAN) && row_ok;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.kind == KIND_WRITE) begin
              state <= wr_ok ? S_WREAD : S_IDLE;
            end else if (outside) begin
              state <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_WREAD:  state <= S_WMOD;
        S_WMOD:   state <= S_IDLE;
        S_SCAN:   state <= (r == RW'(2 * R)) ? S_DRAIN : S_SCAN;
        S_DRAIN:  state <= S_LOOKUP;
        S_LOOKUP: state <= S_MULT;
        S_MULT:   state <= S_EMIT;
        S_EMIT:   state <= out_load ? S_IDLE : S_EMIT;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx   <= in_ch.cell_x;
      qy   <= in_ch.cell_y;
      qocc <= in_ch.occupied;
      r     <= '0;
      found <= 1'b0;
      clr   <= 1'b1;
      res_cost <= '0;
      res_blk  <= 1'b1;
      res_clr  <= 1'b0;
    end
    if (state == S_SCAN) begin
      r     <= r + RW'(1);
      p_ady <= KW'(r_dist);
    end
    if (p_en) begin
      if (soft_row && sfound && (!found || (d2 < best))) begin
        best  <= d2;
        found <= 1'b1;
      end
      if (hard_row && hard_any) begin
        clr <= 1'b0;
      end
    end
    if (state == S_LOOKUP) begin
      res_blk <= best_hard;
      res_clr <= clr;
      n_q     <= (!best_hard && best_soft) ? frac_tab[best[TW-1:0]] : '0;
    end
    if (state == S_MULT) begin
      res_cost <= prod[COST_W+7:8];
    end
  end

  // output register
  assign out_load = (state == S_EMIT) && (!out_vld || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cost <= res_cost;
      out_blk  <= res_blk;
      out_clr  <= res_clr;
    end
  end

  assign out_ch.valid   = out_vld;
  assign out_ch.cost_q8 = out_cost;
  assign out_ch.blocked = out_blk;
  assign out_ch.clear   = out_clr;

endmodule

`default_nettype wire
